// ----- rtl/core/utf8_to_utf16_stream_decoder_unit_assert.svh -----
// Assertion macros for the UTF-8 to UTF-16 decoder, empty when synthesising.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 check failed");
// Next-cycle implication, checked out of reset
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 check failed");
`else
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/u8u16_pkg.sv -----
// Shared types, constants and helpers of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int BYTE_W     = 8;
    localparam int UNIT_W     = 16;
    localparam int COUNT_W    = 2;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 40;   // 34 payload bits padded to whole bytes

    localparam logic [7:0] MASK_TOP1 = 8'h80;
    localparam logic [7:0] MASK_TOP2 = 8'hC0;
    localparam logic [7:0] MASK_TOP3 = 8'hE0;
    localparam logic [7:0] MASK_TOP4 = 8'hF0;
    localparam logic [7:0] MASK_TOP5 = 8'hF8;

    localparam logic [7:0] LEAD2_PAT = 8'hC0;
    localparam logic [7:0] LEAD3_PAT = 8'hE0;
    localparam logic [7:0] LEAD4_PAT = 8'hF0;
    localparam logic [7:0] CONT_PAT  = 8'h80;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

    // Group length minus one
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    localparam logic [1:0] UNITS_ONE = 2'd1;
    localparam logic [1:0] UNITS_TWO = 2'd2;

    // One complete group handed from front to back
    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] is the lead byte
        logic [1:0]      len_m1;
    } t_group;

    // Queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Expected group length, minus one, from the lead byte
    function automatic logic [1:0] group_len_m1(input logic [7:0] lead);
        logic [1:0] len;
        if ((lead & MASK_TOP1) == 8'h00)           len = LEN_1;
        else if ((lead & MASK_TOP3) == LEAD2_PAT)  len = LEN_2;
        else if ((lead & MASK_TOP4) == LEAD3_PAT)  len = LEN_3;
        else if ((lead & MASK_TOP5) == LEAD4_PAT)  len = LEN_4;
        else                                       len = LEN_1;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_TOP2) == CONT_PAT;
    endfunction

endpackage

// ----- rtl/core/u8u16_front.sv -----
// Front end: accepts bytes, gathers a group and hands it on once complete.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [7:0]       i_tdata,     // [7:0] byte_in
    input  t_q_status        i_qstat,
    output logic             o_push,
    output t_group           o_group
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [7:0] r_pend [3];

    logic [7:0] lead;
    logic [1:0] len_m1;
    logic       complete;
    logic       accept;

    // Take a byte whenever the queue has room
    assign o_tready = !i_qstat.full;
    assign accept   = i_tvalid && o_tready;

    // Classify the group from its lead byte
    always_comb begin
        lead     = (r_count == 2'd0) ? i_tdata : r_pend[0];
        len_m1   = group_len_m1(lead);
        complete = (r_count >= len_m1);
    end

    // Assemble the complete group: held bytes, then the new one
    always_comb begin
        o_group.len_m1   = len_m1;
        o_group.bytes[0] = (r_count == 2'd0) ? i_tdata : r_pend[0];
        o_group.bytes[1] = (r_count >= 2'd2) ? r_pend[1] :
                           (r_count == 2'd1) ? i_tdata : 8'h00;
        o_group.bytes[2] = (r_count == 2'd3) ? r_pend[2] :
                           (r_count == 2'd2) ? i_tdata : 8'h00;
        o_group.bytes[3] = (r_count == 2'd3) ? i_tdata : 8'h00;
    end

    assign o_push = accept && complete;

    // Advance or clear the byte count
    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = complete ? 2'd0 : r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold incomplete bytes
    always_ff @(posedge i_clk) begin
        if (accept && !complete) begin
            r_pend[r_count] <= i_tdata;
        end
    end

endmodule

// ----- rtl/core/u8u16_queue.sv -----
// Short queue of complete groups between front and back.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_group    i_group,
    input  logic      i_pop,
    output t_group    o_group,
    output t_q_status o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_group           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_fill == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_fill == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_group = r_mem[r_rd_ptr];

    // Store an incoming group
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Back end: decodes a complete group into UTF-16 units behind an output register.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_group                 i_group,
    input  t_q_status              i_qstat,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,   // [15:0] first_unit, [31:16] second_unit,
                                              // [33:32] unit_count, [39:34] zero
    output logic                   o_tuser    // [0] replaced
);

    logic        r_valid;
    logic [15:0] r_first;
    logic [15:0] r_second;
    logic [1:0]  r_units;
    logic        r_repl;

    logic [20:0] cp;
    logic [19:0] off;
    logic        ok;
    logic [15:0] d_first;
    logic [15:0] d_second;
    logic [1:0]  d_units;
    logic        d_repl;

    // Pop when the output register is free or being drained
    assign o_pop = !i_qstat.empty && (!r_valid || i_tready);

    // Decode the group strictly
    always_comb begin
        cp = '0;
        ok = 1'b0;
        unique case (i_group.len_m1)
            LEN_1: begin
                cp = {13'd0, i_group.bytes[0]};
                ok = !i_group.bytes[0][7];
            end
            LEN_2: begin
                cp = {10'd0, i_group.bytes[0][4:0], i_group.bytes[1][5:0]};
                ok = is_cont(i_group.bytes[1]) && (cp >= 21'h80);
            end
            LEN_3: begin
                cp = {5'd0, i_group.bytes[0][3:0], i_group.bytes[1][5:0],
                      i_group.bytes[2][5:0]};
                ok = is_cont(i_group.bytes[1]) && is_cont(i_group.bytes[2]) &&
                     (cp >= 21'h800) && !((cp >= 21'hD800) && (cp <= 21'hDFFF));
            end
            LEN_4: begin
                cp = {i_group.bytes[0][2:0], i_group.bytes[1][5:0],
                      i_group.bytes[2][5:0], i_group.bytes[3][5:0]};
                ok = is_cont(i_group.bytes[1]) && is_cont(i_group.bytes[2]) &&
                     is_cont(i_group.bytes[3]) &&
                     (cp >= 21'h10000) && (cp <= 21'h10FFFF);
            end
            default: begin
                cp = '0;
                ok = 1'b0;
            end
        endcase
    end

    // Form units: BMP, surrogate pair or replacement
    always_comb begin
        off = cp[19:0] - 20'h10000;
        if (!ok) begin
            d_first  = REPL_UNIT;
            d_second = 16'h0000;
            d_units  = UNITS_ONE;
            d_repl   = 1'b1;
        end else if (cp[20:16] == 5'd0) begin
            d_first  = cp[15:0];
            d_second = 16'h0000;
            d_units  = UNITS_ONE;
            d_repl   = 1'b0;
        end else begin
            d_first  = {HI_SURR_TAG, off[19:10]};
            d_second = {LO_SURR_TAG, off[9:0]};
            d_units  = UNITS_TWO;
            d_repl   = 1'b0;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result item
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first  <= d_first;
            r_second <= d_second;
            r_units  <= d_units;
            r_repl   <= d_repl;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {6'd0, r_units, r_second, r_first};
    assign o_tuser  = r_repl;

endmodule

// ----- rtl/core/utf8_to_utf16_stream_decoder_unit.sv -----
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//  Channel  Dir  Bits  Contents
//  s        in     8   tdata: byte_in
//  m        out   40   tdata: first_unit, second_unit, unit_count; tuser: replaced
//
// One byte is taken every cycle while the group queue has room.
// A result leaves once the byte that completes its group has gone into the group queue
// and the group has then been decoded into the output register.
// Reset clears the byte count, queue pointers and output valid; held bytes are not reset.
// A stalled output fills the queue, and only then is the input held off.
`include "utf8_to_utf16_stream_decoder_unit_assert.svh"

module utf8_to_utf16_stream_decoder_unit
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] byte_in
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [15:0] first_unit, [31:16] second_unit,
                                                // [33:32] unit_count, [39:34] zero
    output logic                   o_m_tuser    // [0] replaced
);

    logic      push;
    logic      pop;
    t_group    front_group;
    t_group    head_group;
    t_q_status qstat;

    logic [15:0] m_first;
    logic [15:0] m_second;
    logic [1:0]  m_units;
    logic        m_single;
    logic        m_pair;
    logic        repl_ok;
    logic        pair_ok;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_group  (front_group)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (front_group),
        .i_pop   (pop),
        .o_group (head_group),
        .o_qstat (qstat)
    );

    u8u16_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_group  (head_group),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

    // Split the result item into its fields for checking
    assign m_first  = o_m_tdata[15:0];
    assign m_second = o_m_tdata[31:16];
    assign m_units  = o_m_tdata[33:32];
    assign m_single = (m_units == UNITS_ONE);
    assign m_pair   = (m_units == UNITS_TWO);
    assign repl_ok  = (m_first == REPL_UNIT) && m_single;
    assign pair_ok  = (m_first[15:10] == HI_SURR_TAG) && (m_second[15:10] == LO_SURR_TAG) &&
                      !o_m_tuser;

    // Replacement items carry exactly one unit, U+FFFD
    `U8U16_ASSERT_NOW(a_repl_form, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, repl_ok)
    // Single-unit items have a zero second unit
    `U8U16_ASSERT_NOW(a_single_zero, i_clk, i_rst_n, o_m_tvalid && m_single, m_second == 16'h0000)
    // Pairs are a high then a low surrogate, never a replacement
    `U8U16_ASSERT_NOW(a_pair_form, i_clk, i_rst_n, o_m_tvalid && m_pair, pair_ok)
    // A pop always leaves a valid result in the next cycle
    `U8U16_ASSERT_NEXT(a_pop_fills, i_clk, i_rst_n, pop, o_m_tvalid)

endmodule
